@@ rtl/slab_bitmap_slot_allocator_top_assert.svh @@
// assertion macros for the slab allocator checker
`ifndef SLAB_BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define SLAB_BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define SBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBA_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/sba_pkg.sv @@
// ---------------------------------------------------------------------------
// sba_pkg
// constants and types shared by the slab allocator files
// ---------------------------------------------------------------------------
package sba_pkg;
   localparam int MaxSlots  = 4096;
   localparam int SlotBits  = $clog2(MaxSlots);
   localparam int CapBits   = SlotBits + 1;
   localparam int WordBits  = 64;
   localparam int WordCount = MaxSlots / WordBits;
   localparam int WordIdx   = $clog2(WordCount);
   localparam int BitIdx    = $clog2(WordBits);
   localparam int AddrBits  = 32;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FOREIGN = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FL_EMPTY   = 2'd0,
      FL_PARTIAL = 2'd1,
      FL_FULL    = 2'd2
   } fill_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_END   = 2'd1;
   localparam logic [1:0] REG_SIZE  = 2'd2;
   localparam logic [1:0] REG_CAP   = 2'd3;
endpackage

@@ rtl/sba_ram.sv @@
// ---------------------------------------------------------------------------
// sba_ram
// single port synchronous ram, registered read
// ---------------------------------------------------------------------------
module sba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

@@ rtl/slab_bitmap_slot_allocator_top.sv @@
// ---------------------------------------------------------------------------
// slab_bitmap_slot_allocator_top
// slab slot allocator keeping a used-slot bitmap in a 64x64 ram
// ---------------------------------------------------------------------------
// allocate: read, read wait and check per bitmap word scanned, then multiply, done,
//    result; straight to done when refused at acceptance; free: 32 division steps,
//    check, read wait, write back, done, result; from the check straight to done on a foreign address
// throughput: one request at a time, busy stays high until rsp_valid
// results cannot be stalled: rsp_valid is a single-cycle strobe
// reset: clearing pass over all 64 words of the bitmap ram, busy high meanwhile;
//    registers return to start 0, end 0, object size 1, capacity 0
module slab_bitmap_slot_allocator_top
   import sba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_object_address,
   output logic [11:0] rsp_slot_number,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_fill_level,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_MUL,
      S_DIV, S_FRD, S_FWAIT, S_FWR, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [31:0] start_ff, end_ff;
   logic [15:0] size_ff;
   logic [12:0] cap_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         REG_START: prdata = start_ff;
         REG_END:   prdata = end_ff;
         REG_SIZE:  prdata = {16'd0, size_ff};
         REG_CAP:   prdata = {19'd0, cap_ff};
         default:   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 32'd0;
         end_ff   <= 32'd0;
         size_ff  <= 16'd1;
         cap_ff   <= 13'd0;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_START: start_ff <= pwdata;
            REG_END:   end_ff   <= pwdata;
            REG_SIZE:  size_ff  <= pwdata[15:0];
            REG_CAP:   cap_ff   <= pwdata[12:0];
            default:   ;
         endcase
      end
   end

   // usable capacity, clipped to the bitmap size
   logic [CapBits-1:0] cap_use;
   assign cap_use = (cap_ff > 13'(MaxSlots)) ? CapBits'(MaxSlots) : CapBits'(cap_ff);

   // bitmap ram
   logic                ram_we;
   logic [WordIdx-1:0]  ram_addr;
   logic [WordBits-1:0] ram_wdata, ram_rdata;

   sba_ram #(.Width(WordBits), .Depth(WordCount)) u_map (
      .clock (clock),
      .wr_en (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   logic [CapBits-1:0]  count_ff;
   logic [WordIdx:0]    word_ff;          // scan / clear word counter
   logic [SlotBits-1:0] slot_ff;
   logic [31:0]         addr_ff;
   logic [1:0]          status_ff;
   logic [31:0]         diff_ff, quot_ff;
   logic [16:0]         rem_ff;
   logic [5:0]          step_ff;

   // lowest clear bit in the word just read
   logic [BitIdx-1:0] low_bit;
   logic              low_found;
   always_comb begin
      low_bit   = '0;
      low_found = 1'b0;
      for (int b = WordBits - 1; b >= 0; b--) begin
         if (!ram_rdata[b]) begin
            low_bit   = BitIdx'(b);
            low_found = 1'b1;
         end
      end
   end

   logic [SlotBits-1:0] cand;
   assign cand = {word_ff[WordIdx-1:0], low_bit};

   // restoring division step
   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   assign rem_sh  = {rem_ff[15:0], diff_ff[31]};
   assign rem_sub = rem_sh - {1'b0, size_ff};

   // slot index times object size, 12 by 16 bits
   logic [27:0] prod;
   assign prod = 28'(slot_ff) * 28'(size_ff);

   always_comb begin
      state_in = state_ff;
      ram_we    = 1'b0;
      ram_addr  = word_ff[WordIdx-1:0];
      ram_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (word_ff == (WordIdx+1)'(WordCount - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_operation == OP_ALLOC) begin
                  state_in = (count_ff >= cap_use) ? S_DONE : S_ARD;
               end else if (count_ff == '0) begin
                  state_in = S_DONE;
               end else if (req_free_address < start_ff || req_free_address >= end_ff
                            || size_ff == 16'd0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_ARD:   state_in = S_AWAIT;
         S_AWAIT: state_in = S_ACHK;
         S_ACHK: begin
            if (low_found && ({1'b0, cand} < cap_use)) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata | (WordBits'(1) << low_bit);
               state_in  = S_MUL;
            end else if (!low_found && ({word_ff, BitIdx'(0)} + (WordIdx+BitIdx+1)'(WordBits)
                                        < (WordIdx+BitIdx+1)'(cap_use))
                         && word_ff != (WordIdx+1)'(WordCount - 1)) begin
               state_in = S_ARD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: state_in = S_DONE;
         S_DIV: if (step_ff == 6'd31) state_in = S_FRD;
         S_FRD: begin
            if (rem_ff != '0 || quot_ff >= 32'(MaxSlots)) state_in = S_DONE;
            else state_in = S_FWAIT;
         end
         S_FWAIT: state_in = S_FWR;
         S_FWR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(WordBits'(1) << slot_ff[BitIdx-1:0]);
            state_in  = S_DONE;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_FWAIT || state_ff == S_FWR || state_ff == S_FRD) begin
         ram_addr = (state_ff == S_FRD) ? quot_ff[SlotBits-1:BitIdx]
                                        : slot_ff[SlotBits-1:BitIdx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         word_ff   <= '0;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == S_DONE);
         case (state_ff)
            S_CLEAR: word_ff <= word_ff + 1'b1;
            S_IDLE: begin
               word_ff   <= '0;
               slot_ff   <= '0;
               addr_ff   <= '0;
               diff_ff   <= req_free_address - start_ff;
               rem_ff    <= '0;
               quot_ff   <= '0;
               step_ff   <= '0;
               status_ff <= ST_OK;
               if (req_operation == OP_ALLOC) begin
                  if (count_ff >= cap_use) status_ff <= ST_FULL;
               end else if (count_ff == '0) begin
                  status_ff <= ST_EMPTY;
               end else if (req_free_address < start_ff || req_free_address >= end_ff
                            || size_ff == 16'd0) begin
                  status_ff <= ST_FOREIGN;
               end
            end
            S_ACHK: begin
               if (low_found && ({1'b0, cand} < cap_use)) begin
                  slot_ff  <= cand;
                  count_ff <= count_ff + 1'b1;
               end else if (!low_found && ({word_ff, BitIdx'(0)} + (WordIdx+BitIdx+1)'(WordBits)
                                           < (WordIdx+BitIdx+1)'(cap_use))
                            && word_ff != (WordIdx+1)'(WordCount - 1)) begin
                  word_ff <= word_ff + 1'b1;
               end else begin
                  status_ff <= ST_FULL;
               end
            end
            S_MUL: addr_ff <= start_ff + 32'(prod);
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               diff_ff <= {diff_ff[30:0], 1'b0};
               if (!rem_sub[16]) begin
                  rem_ff  <= rem_sub;
                  quot_ff <= {quot_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  quot_ff <= {quot_ff[30:0], 1'b0};
               end
            end
            S_FRD: begin
               if (rem_ff != '0 || quot_ff >= 32'(MaxSlots)) status_ff <= ST_FOREIGN;
               else slot_ff <= quot_ff[SlotBits-1:0];
            end
            S_FWR: count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

   // result outputs, valid for one cycle after S_DONE
   logic [1:0] fill;
   always_comb begin
      if (count_ff == '0) fill = FL_EMPTY;
      else if (count_ff >= cap_use) fill = FL_FULL;
      else fill = FL_PARTIAL;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         rsp_object_address <= (status_ff == ST_OK) ? addr_ff : 32'd0;
         rsp_slot_number    <= (status_ff == ST_OK) ? slot_ff : 12'd0;
         rsp_status         <= status_ff;
         rsp_fill_level     <= fill;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule

@@ rtl/sba_checker.sv @@
// ---------------------------------------------------------------------------
// sba_checker
// port-level checks for the slab allocator
// ---------------------------------------------------------------------------
`include "slab_bitmap_slot_allocator_top_assert.svh"
module sba_checker
   import sba_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_fill_level,
   input logic [31:0] rsp_object_address
);
   `SBA_ASSERT(a_busy_after_start, clock, reset, start && !busy |=> busy, "start not taken")
   `SBA_ASSERT(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid, "strobe too long")
   `SBA_ASSERT(a_fill_range, clock, reset, rsp_valid |-> rsp_fill_level <= FL_FULL, "bad fill")
   `SBA_ASSERT(a_fail_zero, clock, reset,
      rsp_valid && rsp_status != ST_OK |-> rsp_object_address == 32'd0, "address on failure")
   `SBA_ASSERT_NR(a_reset_busy, clock, $past(reset) && !reset |-> busy, "busy after reset")
endmodule

bind slab_bitmap_slot_allocator_top sba_checker u_sba_checker (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_valid (rsp_valid), .rsp_status (rsp_status),
   .rsp_fill_level (rsp_fill_level), .rsp_object_address (rsp_object_address)
);

@@ tb/tb_slab_bitmap_slot_allocator_top.sv @@
// ---------------------------------------------------------------------------
// tb_slab_bitmap_slot_allocator_top
// self-checking bench for the slab slot allocator: a directed table with
// typed answers for the obvious rows, then randomized phases over many slab
// layouts. untyped responses are compared with a bitmap/count shadow model.
// ---------------------------------------------------------------------------
module tb_slab_bitmap_slot_allocator_top;
   import sba_pkg::*;

   // response fields as one record
   typedef struct packed {
      logic [31:0] obj_addr;
      logic [11:0] slot;
      status_type  st;
      fill_type    fill;
   } slot_result_type;

   // one line of the directed table: a register write or a request
   typedef struct {
      bit              is_cfg;
      logic [1:0]      reg_idx;
      logic [31:0]     value;     // register value, or free address of a request
      logic            op;
      bit              typed;     // expected response typed in below
      slot_result_type answer;
   } table_row_type;

   localparam int TableRows = 36;
   localparam int RandomItems = 1850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_ALLOC;
   logic [31:0] req_free_address = '0;
   logic        rsp_valid;
   logic [31:0] rsp_object_address;
   logic [11:0] rsp_slot_number;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_fill_level;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // shadow copy of the allocator state and registers
   bit [MaxSlots-1:0] used_slots;
   int unsigned       used_total;
   logic [31:0]       slab_base, slab_limit, obj_bytes, cap_reg;

   slot_result_type pending_results[$];
   int unsigned     fail_count = 0;

   slab_bitmap_slot_allocator_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_free_address   (req_free_address),
      .rsp_valid          (rsp_valid),
      .rsp_object_address (rsp_object_address),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_status         (rsp_status),
      .rsp_fill_level     (rsp_fill_level),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 2-unit clock period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // directed table: reset defaults, a small slab, a slab at the top of the
   // address space, zero object size, and the largest bitmap
   table_row_type dir_table [TableRows] = '{
      // capacity zero after reset: allocate is refused, free finds nothing
      '{0, REG_START, 32'h0,        OP_ALLOC, 1, '{32'h0, 12'd0, ST_FULL, FL_EMPTY}},
      '{0, REG_START, 32'hFFFFFFFF, OP_FREE,  1, '{32'h0, 12'd0, ST_EMPTY, FL_EMPTY}},
      '{1, REG_START, 32'h1000,     OP_ALLOC, 0, '0},
      '{1, REG_END,   32'h1100,     OP_ALLOC, 0, '0},
      '{1, REG_SIZE,  32'h10,       OP_ALLOC, 0, '0},
      '{1, REG_CAP,   32'd4,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 1, '{32'h1000, 12'd0, ST_OK, FL_PARTIAL}},
      '{0, REG_START, 32'h0,        OP_ALLOC, 1, '{32'h1010, 12'd1, ST_OK, FL_PARTIAL}},
      // misaligned, below the slab, at the end address
      '{0, REG_START, 32'h1008,     OP_FREE,  1, '{32'h0, 12'd0, ST_FOREIGN, FL_PARTIAL}},
      '{0, REG_START, 32'h0FFF,     OP_FREE,  1, '{32'h0, 12'd0, ST_FOREIGN, FL_PARTIAL}},
      '{0, REG_START, 32'h1100,     OP_FREE,  1, '{32'h0, 12'd0, ST_FOREIGN, FL_PARTIAL}},
      // fill up and run over
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      // double free still drops the count
      '{0, REG_START, 32'h1010,     OP_FREE,  0, '0},
      '{0, REG_START, 32'h1010,     OP_FREE,  0, '0},
      '{0, REG_START, 32'h1000,     OP_FREE,  0, '0},
      '{0, REG_START, 32'h1030,     OP_FREE,  0, '0},
      // slab at the top: addresses wrap, capacity beyond the bitmap
      '{1, REG_START, 32'hFFFFFF00, OP_ALLOC, 0, '0},
      '{1, REG_END,   32'hFFFFFFFF, OP_ALLOC, 0, '0},
      '{1, REG_SIZE,  32'hFFFF,     OP_ALLOC, 0, '0},
      '{1, REG_CAP,   32'h1FFF,     OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'hFFFFFF00, OP_FREE,  0, '0},
      '{0, REG_START, 32'h0,        OP_FREE,  0, '0},
      // zero object size
      '{1, REG_SIZE,  32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'hFFFFFF00, OP_FREE,  0, '0},
      // whole address space, byte slots, full bitmap
      '{1, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{1, REG_END,   32'hFFFFFFFF, OP_ALLOC, 0, '0},
      '{1, REG_SIZE,  32'h1,        OP_ALLOC, 0, '0},
      '{1, REG_CAP,   32'd4096,     OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h0,        OP_ALLOC, 0, '0},
      '{0, REG_START, 32'h1000,     OP_FREE,  0, '0},  // index past the bitmap
      '{0, REG_START, 32'hFFFFFFFE, OP_FREE,  0, '0}
   };

   // shadow allocator: updates the bitmap and count, returns the response
   function automatic slot_result_type allocate_or_free(logic op, logic [31:0] addr);
      slot_result_type   r;
      int unsigned       cap;
      int unsigned       i;
      longint unsigned   diff;
      longint unsigned   idx;
      r = '{32'h0, 12'd0, ST_OK, FL_EMPTY};
      cap = (cap_reg > MaxSlots) ? MaxSlots : cap_reg;
      if (op == OP_ALLOC) begin
         if (used_total >= cap) begin
            r.st = ST_FULL;
         end else begin
            i = 0;
            while (i < cap && used_slots[i]) i++;
            if (i >= cap) begin
               r.st = ST_FULL;
            end else begin
               used_slots[i] = 1'b1;
               used_total++;
               r.slot = i[11:0];
               // wraps modulo 2^32
               r.obj_addr = 32'(longint'(slab_base) + longint'(i) * longint'(obj_bytes));
            end
         end
      end else begin
         if (used_total == 0) begin
            r.st = ST_EMPTY;
         end else if (addr < slab_base || addr >= slab_limit || obj_bytes == 0) begin
            r.st = ST_FOREIGN;
         end else begin
            diff = longint'(addr) - longint'(slab_base);
            idx = diff / obj_bytes;
            if (diff % obj_bytes != 0 || idx >= MaxSlots) begin
               r.st = ST_FOREIGN;
            end else begin
               used_slots[idx] = 1'b0;   // may already be clear
               used_total--;
               r.slot = idx[11:0];
            end
         end
      end
      if (used_total == 0) r.fill = FL_EMPTY;
      else if (used_total >= cap) r.fill = FL_FULL;
      else r.fill = FL_PARTIAL;
      return r;
   endfunction

   // response checker: oldest expectation first
   always @(posedge clock) begin
      slot_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with none pending: got %h %h %0d %0d", $time,
                     rsp_object_address, rsp_slot_number, rsp_status, rsp_fill_level);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_object_address !== want.obj_addr) begin
               $display("%0t: object_address expected %h actual %h", $time,
                        want.obj_addr, rsp_object_address);
               fail_count++;
            end
            if (rsp_slot_number !== want.slot) begin
               $display("%0t: slot_number expected %0d actual %0d", $time,
                        want.slot, rsp_slot_number);
               fail_count++;
            end
            if (rsp_status !== want.st) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.st, rsp_status);
               fail_count++;
            end
            if (rsp_fill_level !== want.fill) begin
               $display("%0t: fill_level expected %0d actual %0d", $time,
                        want.fill, rsp_fill_level);
               fail_count++;
            end
         end
      end
   end

   // one apb transfer, setup then access
   task automatic csr_transfer(input logic wr, input logic [1:0] idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = {idx, 2'b00};
      pwdata = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // wait until the allocator has answered everything, start held low
   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write a register between phases and read it back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] back;
      drain();
      case (idx)
         REG_SIZE: mask = 32'h0000FFFF;
         REG_CAP:  mask = 32'h00001FFF;
         default:  mask = 32'hFFFFFFFF;
      endcase
      csr_transfer(1'b1, idx, value, back);
      case (idx)
         REG_START: slab_base = value & mask;
         REG_END:   slab_limit = value & mask;
         REG_SIZE:  obj_bytes = value & mask;
         default:   cap_reg = value & mask;
      endcase
      csr_transfer(1'b0, idx, 32'h0, back);
      if ((back & mask) !== (value & mask)) begin
         $display("%0t: register %0d read expected %h actual %h", $time, idx,
                  value & mask, back);
         fail_count++;
      end
   endtask

   // present one request, wait for acceptance, queue its answer
   task automatic issue_request(input logic op, input logic [31:0] addr,
                                input int unsigned idle_pct, input bit typed,
                                input slot_result_type answer);
      slot_result_type model;
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_operation = op;
      req_free_address = addr;
      do @(posedge clock); while (busy);
      model = allocate_or_free(op, addr);
      pending_results.push_back(typed ? answer : model);
   endtask

   // generous limit on the whole run
   initial begin
      #6000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [31:0]  rd;
      logic [31:0]  base, sz, cp, fa;
      int unsigned  kind, n, k, idle_pct;
      used_slots = '0;
      used_total = 0;
      slab_base = 32'h0;
      slab_limit = 32'h0;
      obj_bytes = 32'h1;
      cap_reg = 32'h0;

      // reset held high, then released for the bitmap clearing pass
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (busy) @(posedge clock);

      // registers come up at start 0, end 0, size 1, capacity 0; start and size are checked
      csr_transfer(1'b0, REG_START, 32'h0, rd);
      if (rd !== 32'h0) begin
         $display("%0t: start after reset expected 0 actual %h", $time, rd);
         fail_count++;
      end
      csr_transfer(1'b0, REG_SIZE, 32'h0, rd);
      if (rd[15:0] !== 16'h1) begin
         $display("%0t: size after reset expected 1 actual %h", $time, rd);
         fail_count++;
      end

      // directed table
      foreach (dir_table[i]) begin
         if (dir_table[i].is_cfg)
            csr_write(dir_table[i].reg_idx, dir_table[i].value);
         else
            issue_request(dir_table[i].op, dir_table[i].value, 0,
                          dir_table[i].typed, dir_table[i].answer);
      end

      // random phases, each with a fresh slab layout
      n = 0;
      while (n < RandomItems) begin
         kind = $urandom_range(9);
         base = $urandom;
         if (kind == 0) begin
            // largest bitmap, byte slots
            sz = 1;
            cp = 4096;
         end else if (kind == 1) begin
            // capacity beyond the bitmap
            sz = $urandom_range(1, 65535);
            cp = $urandom_range(4097, 8191);
         end else if (kind == 2) begin
            sz = 0;
            cp = $urandom_range(1, 16);
         end else begin
            case ($urandom_range(4))
               0: sz = 1;
               1: sz = 4;
               2: sz = 65535;
               default: sz = $urandom_range(1, 300);
            endcase
            cp = $urandom_range(1, 48);
         end
         if ($urandom_range(5) == 0) base = 32'hFFFFFFFF - $urandom_range(4096);
         csr_write(REG_START, base);
         csr_write(REG_END, ($urandom_range(4) == 0) ? $urandom :
                            base + cp * sz + $urandom_range(2 * sz));
         csr_write(REG_SIZE, sz);
         csr_write(REG_CAP, cp);
         for (k = 0; k < 60 && n < RandomItems; k++) begin
            // sender idles 10%, then 58%, then not at all
            idle_pct = (n < RandomItems / 3) ? 10 : (n < 2 * RandomItems / 3) ? 58 : 0;
            if (n == RandomItems / 2) drain();   // hold off until all answered
            case ($urandom_range(9))
               0, 1:    fa = $urandom;
               2:       fa = base + $urandom_range(3 * (sz + 1));
               default: fa = base + $urandom_range(cp + 2) * sz;
            endcase
            issue_request(($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE, fa,
                          idle_pct, 1'b0, '0);
            n++;
         end
      end

      // everything answered, then allow the longest scan to settle
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
